// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is low.
`define CPWCM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpwcm check failed");

// Clocked check that also runs across reset.
`define CPWCM_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cpwcm reset check failed");

`endif

// ===== rtl/cpwcm_pkg.sv =====
`timescale 1ns / 1ps
package cpwcm_pkg;

    localparam int ATAN_LEN  = 24;
    localparam int ZW        = 28;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int LEVEL_W   = 8;
    localparam int WIN_W     = 32;
    localparam int CHAN_W    = 17;

    localparam longint PI_Q             = 52707179;
    localparam longint HALF_PI_Q        = 26353589;
    localparam longint TWO_PI_Q         = 105414357;
    localparam longint THIRD_TURN_Q     = 35138119;
    localparam longint TWO_THIRD_TURN_Q = 70276238;
    localparam longint CORDIC_K_Q       = 10188014;
    localparam longint DEG_PER_RAD_Q16  = 3754936;
    localparam longint ONE_Q24          = 16777216;
    localparam longint FULL_SCALE       = 255 * ONE_Q24;
    localparam longint RECIP_255        = (64'sd1 <<< 24) / 255;

    typedef enum logic [2:0] {
        MODE_MAG   = 3'd0,
        MODE_REAL  = 3'd1,
        MODE_IMAG  = 3'd2,
        MODE_CPLX  = 3'd3,
        MODE_PHASE = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_MODE     = 3'd0,
        REG_PHASE_IN_DEGREES = 3'd1,
        REG_WINDOW_LOW       = 3'd2,
        REG_WINDOW_GAIN      = 3'd3,
        REG_WINDOW_VALID     = 3'd4,
        REG_FULL_BRIGHT      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [2:0]         display_mode;
        logic               phase_in_degrees;
        logic signed [17:0] window_low;
        logic [23:0]        window_gain;
        logic               window_valid;
        logic               full_bright;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic frame_end;
    } tag_t;

    typedef struct packed {
        logic signed [15:0] real_part;
        logic signed [15:0] imag_part;
        logic               frame_end;
    } pixel_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic               frame_end_out;
    } colour_t;

    function automatic longint atan_q24(int i);
        longint v;
        case (i)
            0:  v = 13176795;
            1:  v = 7778716;
            2:  v = 4110060;
            3:  v = 2086331;
            4:  v = 1047214;
            5:  v = 524117;
            6:  v = 262123;
            7:  v = 131069;
            8:  v = 65536;
            9:  v = 32768;
            10: v = 16384;
            11: v = 8192;
            12: v = 4096;
            13: v = 2048;
            14: v = 1024;
            15: v = 512;
            16: v = 256;
            17: v = 128;
            18: v = 64;
            19: v = 32;
            20: v = 16;
            21: v = 8;
            22: v = 4;
            23: v = 2;
            default: v = 0;
        endcase
        return v;
    endfunction

    function automatic longint sine_q24(longint a_in, int n);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     i;
        a = a_in;
        x = CORDIC_K_Q;
        y = 0;
        if (a > PI_Q)
            a = a - TWO_PI_Q;
        if (a > PI_Q)
            a = a - TWO_PI_Q;
        if (a > HALF_PI_Q)
            a = PI_Q - a;
        else if (a < -HALF_PI_Q)
            a = -PI_Q - a;
        z = a;
        for (i = 0; i < n; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q24(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q24(i);
            end
        end
        return y;
    endfunction

    function automatic logic [CHAN_W-1:0] channel_q16(longint a, int n);
        longint v;
        longint c;
        v = sine_q24(a, n) + ONE_Q24;
        if (v < 0)
            v = 0;
        c = (v + 256) >>> 9;
        if (c > 65536)
            c = 65536;
        return CHAN_W'(c);
    endfunction

endpackage

// ===== rtl/cpwcm_cordic.sv =====
`timescale 1ns / 1ps
module cpwcm_cordic
    import cpwcm_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  tag_t                          in_tag,
    input  logic signed [SAMPLE_BITS-1:0] re,
    input  logic signed [SAMPLE_BITS-1:0] im,
    output tag_t                          out_tag,
    output logic signed [SAMPLE_BITS+10:0] x_out,
    output logic signed [ZW-1:0]          z_out,
    output logic signed [SAMPLE_BITS-1:0] re_out,
    output logic signed [SAMPLE_BITS-1:0] im_out
);

    localparam int XW = SAMPLE_BITS + 11;
    localparam int NS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    tag_t                          tag_reg  [0:NS];
    logic signed [XW-1:0]          x_reg    [0:NS];
    logic signed [XW-1:0]          y_reg    [0:NS];
    logic signed [ZW-1:0]          z_reg    [0:NS];
    logic signed [SAMPLE_BITS-1:0] re_reg   [0:NS];
    logic signed [SAMPLE_BITS-1:0] im_reg   [0:NS];
    logic                          zero_reg [0:NS];

    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    assign x0 = {{3{re[SAMPLE_BITS-1]}}, re, 8'd0};
    assign y0 = {{3{im[SAMPLE_BITS-1]}}, im, 8'd0};

    // Fold the left half plane onto the right one.
    always_comb
    begin
        x_next = x0;
        y_next = y0;
        z_next = '0;
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                x_next = y0;
                y_next = -x0;
                z_next = ZW'(HALF_PI_Q);
            end
            else
            begin
                x_next = -y0;
                y_next = x0;
                z_next = -ZW'(HALF_PI_Q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg[0] <= '0;
        else if (en)
            tag_reg[0] <= in_tag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            re_reg[0]   <= re;
            im_reg[0]   <= im;
            zero_reg[0] <= (re == '0) && (im == '0);
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_q24(i));

        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [XW-1:0] xs_next;
        logic signed [XW-1:0] ys_next;
        logic signed [ZW-1:0] zs_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (y_reg[i] >= 0)
            begin
                xs_next = x_reg[i] + dx;
                ys_next = y_reg[i] - dy;
                zs_next = z_reg[i] + ATAN_I;
            end
            else
            begin
                xs_next = x_reg[i] - dx;
                ys_next = y_reg[i] + dy;
                zs_next = z_reg[i] - ATAN_I;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[i+1] <= '0;
            else if (en)
                tag_reg[i+1] <= tag_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= xs_next;
                y_reg[i+1]    <= ys_next;
                z_reg[i+1]    <= zs_next;
                re_reg[i+1]   <= re_reg[i];
                im_reg[i+1]   <= im_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign out_tag = tag_reg[NS];
    assign x_out   = zero_reg[NS] ? '0 : x_reg[NS];
    assign z_out   = zero_reg[NS] ? '0 : z_reg[NS];
    assign re_out  = re_reg[NS];
    assign im_out  = im_reg[NS];

endmodule

// ===== rtl/cpwcm_window.sv =====
`timescale 1ns / 1ps
module cpwcm_window
    import cpwcm_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COLOUR_ENTRIES = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  cfg_t                                  cfg,
    input  tag_t                                  in_tag,
    input  logic signed [SAMPLE_BITS+10:0]        x,
    input  logic signed [ZW-1:0]                  z,
    input  logic signed [SAMPLE_BITS-1:0]         re,
    input  logic signed [SAMPLE_BITS-1:0]         im,
    output tag_t                                  out_tag,
    output logic [$clog2(COLOUR_ENTRIES)-1:0]     idx,
    output logic [WIN_W-1:0]                      bright,
    output logic [LEVEL_W-1:0]                    grey
);

    localparam int     XW   = SAMPLE_BITS + 11;
    localparam int     IW   = $clog2(COLOUR_ENTRIES);
    localparam longint D    = COLOUR_ENTRIES - 1;
    localparam int     MW   = XW + 25;
    localparam int     DGW  = ZW + 23;
    localparam int     TW   = 27;
    localparam int     NUMW = TW + IW + 1;
    localparam longint RK   = (D * (64'sd1 <<< 30) + TWO_PI_Q / 2) / TWO_PI_Q;
    localparam int     RKW  = IW + 5;
    localparam int     QMW  = TW + RKW;
    localparam int     QW   = IW + 1;
    localparam int     QPW  = QW + TW;
    localparam int     VW   = (XW > 24) ? XW : 24;
    localparam int     DFW  = ((VW > 26) ? VW : 26) + 1;
    localparam int     WPW  = DFW + 25;
    localparam int     UW   = WIN_W + IW + 1;
    localparam int     XQW  = UW - 24;
    localparam int     PMW  = XQW + 17;

    // Stage A: magnitude and degree products, complex index estimate
    tag_t                   tag_a_reg;
    logic signed [MW-1:0]   mprod_a_reg;
    logic signed [DGW-1:0]  dprod_a_reg;
    logic signed [ZW-1:0]   z_a_reg;
    logic signed [SAMPLE_BITS-1:0] re_a_reg;
    logic signed [SAMPLE_BITS-1:0] im_a_reg;
    logic [NUMW-1:0]        numc_a_reg;
    logic [QMW-1:0]         q0mc_a_reg;

    logic signed [ZW:0]     tz;
    logic [TW-1:0]          t;
    logic signed [MW-1:0]   mprod_next;
    logic signed [DGW-1:0]  dprod_next;
    logic [NUMW-1:0]        numc_next;
    logic [QMW-1:0]         q0mc_next;

    always_comb
    begin
        tz         = (ZW+1)'(z) + (ZW+1)'(PI_Q);
        t          = (tz < 0) ? '0 : tz[TW-1:0];
        numc_next  = NUMW'(t) * NUMW'(D) + NUMW'(TWO_PI_Q / 2);
        q0mc_next  = QMW'(t) * QMW'(RK);
        mprod_next = MW'(x) * MW'(CORDIC_K_Q);
        dprod_next = DGW'(z) * DGW'(DEG_PER_RAD_Q16);
    end

    // Stage B: pick the windowed value, complex index remainder product
    tag_t                   tag_b_reg;
    logic signed [DFW-1:0]  diff_b_reg;
    logic [QW-1:0]          qc_b_reg;
    logic [QPW-1:0]         qpc_b_reg;
    logic [NUMW-1:0]        numc_b_reg;

    logic signed [MW-1:0]   mag_full;
    logic signed [DGW-1:0]  deg_full;
    logic signed [ZW-1:0]   rad_full;
    logic signed [VW-1:0]   vsel;
    logic signed [DFW-1:0]  diff_next;
    logic [QW-1:0]          qc_next;
    logic [QPW-1:0]         qpc_next;

    always_comb
    begin
        mag_full = (mprod_a_reg + MW'(ONE_Q24 / 2)) >>> 24;
        deg_full = (dprod_a_reg + DGW'(64'sd1 <<< 25)) >>> 26;
        rad_full = (z_a_reg + ZW'(8)) >>> 4;
        unique case (cfg.display_mode)
            MODE_REAL:  vsel = VW'($signed({re_a_reg, 8'd0}));
            MODE_IMAG:  vsel = VW'($signed({im_a_reg, 8'd0}));
            MODE_PHASE: vsel = cfg.phase_in_degrees ? VW'(deg_full) : VW'(rad_full);
            default:    vsel = VW'(mag_full);
        endcase
        diff_next = DFW'(vsel) - DFW'($signed({cfg.window_low, 8'd0}));
        qc_next   = QW'((q0mc_a_reg + QMW'(64'd1 << 29)) >> 30);
        qpc_next  = QPW'(qc_next) * QPW'(TWO_PI_Q);
    end

    // Stage C: window product, complex index correction
    tag_t                   tag_c_reg;
    logic signed [WPW-1:0]  wprod_c_reg;
    logic [QW-1:0]          idxc_c_reg;

    logic signed [NUMW:0]   rem;
    logic signed [WPW-1:0]  wprod_next;
    logic [QW-1:0]          idxc_next;

    always_comb
    begin
        wprod_next = WPW'(diff_b_reg) * WPW'($signed({1'b0, cfg.window_gain}));
        rem        = $signed({1'b0, numc_b_reg}) - $signed({1'b0, qpc_b_reg});
        if (rem < 0)
            idxc_next = qc_b_reg - QW'(1);
        else if (rem >= (NUMW+1)'(TWO_PI_Q))
            idxc_next = qc_b_reg + QW'(1);
        else
            idxc_next = qc_b_reg;
    end

    // Stage D: clamp, phase index product
    tag_t                   tag_d_reg;
    logic [WIN_W-1:0]       w_d_reg;
    logic [UW-1:0]          uprod_d_reg;
    logic [QW-1:0]          idxc_d_reg;

    logic [WIN_W-1:0]       w_next;
    logic [UW-1:0]          uprod_next;

    always_comb
    begin
        if (wprod_c_reg < 0)
            w_next = '0;
        else if (wprod_c_reg > WPW'(FULL_SCALE))
            w_next = WIN_W'(FULL_SCALE);
        else
            w_next = WIN_W'(wprod_c_reg);
        uprod_next = UW'(w_next) * UW'(D) + UW'(FULL_SCALE / 2);
    end

    // Stage E: divide by 255 estimate
    tag_t                   tag_e_reg;
    logic [WIN_W-1:0]       w_e_reg;
    logic [XQW-1:0]         xq_e_reg;
    logic [QW-1:0]          q0p_e_reg;
    logic [QW-1:0]          idxc_e_reg;

    logic [XQW-1:0]         xq;
    logic [PMW-1:0]         qprod;
    logic [QW-1:0]          q0p_next;

    always_comb
    begin
        xq       = uprod_d_reg[UW-1:24];
        qprod    = PMW'(xq) * PMW'(RECIP_255);
        q0p_next = QW'(qprod >> 24);
    end

    // Stage F: correct, select index, brightness and grey
    tag_t                   tag_f_reg;
    logic [IW-1:0]          idx_f_reg;
    logic [WIN_W-1:0]       bright_f_reg;
    logic [LEVEL_W-1:0]     grey_f_reg;

    logic [XQW-1:0]         q255;
    logic [XQW-1:0]         rq;
    logic [QW-1:0]          idxp;
    logic [IW-1:0]          idx_next;
    logic [WIN_W-1:0]       bright_next;
    logic [WIN_W:0]         grey_sum;
    logic [LEVEL_W-1:0]     grey_next;

    always_comb
    begin
        q255 = XQW'({q0p_e_reg, 8'd0}) - XQW'(q0p_e_reg);
        rq   = xq_e_reg - q255;
        idxp = (rq >= XQW'(255)) ? q0p_e_reg + QW'(1) : q0p_e_reg;
        unique case (cfg.display_mode)
            MODE_CPLX:
                idx_next = (idxc_e_reg > QW'(D)) ? IW'(D) : IW'(idxc_e_reg);
            MODE_PHASE:
            begin
                if (!cfg.window_valid)
                    idx_next = '0;
                else
                    idx_next = (idxp > QW'(D)) ? IW'(D) : IW'(idxp);
            end
            default:
                idx_next = '0;
        endcase
        bright_next = cfg.full_bright ? WIN_W'(FULL_SCALE) : w_e_reg;
        grey_sum    = (WIN_W+1)'(w_e_reg) + (WIN_W+1)'(ONE_Q24 / 2);
        grey_next   = LEVEL_W'(grey_sum >> 24);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            tag_e_reg <= '0;
            tag_f_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
            tag_e_reg <= tag_d_reg;
            tag_f_reg <= tag_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mprod_a_reg  <= mprod_next;
            dprod_a_reg  <= dprod_next;
            z_a_reg      <= z;
            re_a_reg     <= re;
            im_a_reg     <= im;
            numc_a_reg   <= numc_next;
            q0mc_a_reg   <= q0mc_next;

            diff_b_reg   <= diff_next;
            qc_b_reg     <= qc_next;
            qpc_b_reg    <= qpc_next;
            numc_b_reg   <= numc_a_reg;

            wprod_c_reg  <= wprod_next;
            idxc_c_reg   <= idxc_next;

            w_d_reg      <= w_next;
            uprod_d_reg  <= uprod_next;
            idxc_d_reg   <= idxc_c_reg;

            w_e_reg      <= w_d_reg;
            xq_e_reg     <= xq;
            q0p_e_reg    <= q0p_next;
            idxc_e_reg   <= idxc_d_reg;

            idx_f_reg    <= idx_next;
            bright_f_reg <= bright_next;
            grey_f_reg   <= grey_next;
        end
    end

    assign out_tag = tag_f_reg;
    assign idx     = idx_f_reg;
    assign bright  = bright_f_reg;
    assign grey    = grey_f_reg;

endmodule

// ===== rtl/cpwcm_colour.sv =====
`timescale 1ns / 1ps
module cpwcm_colour
    import cpwcm_pkg::*;
#(
    parameter int COLOUR_ENTRIES = 256,
    parameter int CORDIC_STAGES  = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  cfg_t                              cfg,
    input  tag_t                              in_tag,
    input  logic [$clog2(COLOUR_ENTRIES)-1:0] idx,
    input  logic [WIN_W-1:0]                  bright,
    input  logic [LEVEL_W-1:0]                grey,
    output logic                              out_valid,
    output colour_t                           out_colour
);

    localparam longint D   = COLOUR_ENTRIES - 1;
    localparam int     NS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int     PKW = CHAN_W + WIN_W;

    logic [CHAN_W-1:0] map_r [COLOUR_ENTRIES];
    logic [CHAN_W-1:0] map_g [COLOUR_ENTRIES];
    logic [CHAN_W-1:0] map_b [COLOUR_ENTRIES];

    for (genvar i = 0; i < COLOUR_ENTRIES; i++)
    begin : g_map
        localparam longint ANG = (longint'(i) * TWO_PI_Q + D / 2) / D;
        assign map_r[i] = channel_q16(ANG, NS);
        assign map_g[i] = channel_q16(ANG + THIRD_TURN_Q, NS);
        assign map_b[i] = channel_q16(ANG + TWO_THIRD_TURN_Q, NS);
    end

    tag_t               tag_g_reg;
    logic [CHAN_W-1:0]  c_g_reg [3];
    logic [WIN_W-1:0]   bright_g_reg;
    logic [LEVEL_W-1:0] grey_g_reg;

    tag_t               tag_h_reg;
    logic [PKW-1:0]     pk_h_reg [3];
    logic [LEVEL_W-1:0] grey_h_reg;

    logic               valid_reg;
    colour_t            colour_reg;

    logic [WIN_W-1:0]   fac;
    logic [PKW-1:0]     pk_next [3];
    logic [PKW-1:0]     sum;
    logic [PKW-1:0]     lv_wide;
    logic [LEVEL_W-1:0] lv [3];
    colour_t            colour_next;

    always_comb
    begin
        fac = (cfg.display_mode == MODE_CPLX) ? bright_g_reg : WIN_W'(255);
        for (int k = 0; k < 3; k++)
            pk_next[k] = PKW'(c_g_reg[k]) * PKW'(fac);
    end

    always_comb
    begin
        sum     = '0;
        lv_wide = '0;
        for (int k = 0; k < 3; k++)
        begin
            unique case (cfg.display_mode)
                MODE_MAG, MODE_REAL, MODE_IMAG:
                begin
                    if (cfg.window_valid)
                        lv[k] = grey_h_reg;
                    else
                        lv[k] = cfg.full_bright ? LEVEL_W'(255) : '0;
                end
                MODE_CPLX:
                begin
                    sum     = pk_h_reg[k] + PKW'(64'd1 << 39);
                    lv_wide = sum >> 40;
                    lv[k]   = (lv_wide > PKW'(255)) ? LEVEL_W'(255) : LEVEL_W'(lv_wide);
                end
                MODE_PHASE:
                begin
                    sum     = pk_h_reg[k] + PKW'(32768);
                    lv_wide = sum >> 16;
                    lv[k]   = (lv_wide > PKW'(255)) ? LEVEL_W'(255) : LEVEL_W'(lv_wide);
                end
                default:
                    lv[k] = '0;
            endcase
        end
        colour_next.red_level     = lv[0];
        colour_next.green_level   = lv[1];
        colour_next.blue_level    = lv[2];
        colour_next.frame_end_out = tag_h_reg.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_g_reg <= '0;
            tag_h_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tag_g_reg <= in_tag;
            tag_h_reg <= tag_g_reg;
            valid_reg <= tag_h_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_g_reg[0]   <= map_r[idx];
            c_g_reg[1]   <= map_g[idx];
            c_g_reg[2]   <= map_b[idx];
            bright_g_reg <= bright;
            grey_g_reg   <= grey;
            for (int k = 0; k < 3; k++)
                pk_h_reg[k] <= pk_next[k];
            grey_h_reg   <= grey_g_reg;
            colour_reg   <= colour_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_colour = colour_reg;

endmodule

// ===== rtl/complex_pixel_window_colour_map.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                     Payload
// pixel     pixel_valid / pixel_ready     pixel (pixel_t)
// colour    colour_valid / colour_ready   colour (colour_t)
// config    cfg_write                     cfg_index, cfg_data
//
// One pixel enters per cycle while the output is not stalled; each pixel passes through the
// vectoring CORDIC chain (CORDIC length capped at 24) and then the window and map stages.
// Reset clears all valid bits and the configuration registers to zero.
// A stalled output freezes the whole pipeline; pixel_ready drops in the same cycle.
module complex_pixel_window_colour_map
    import cpwcm_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COLOUR_ENTRIES = 256,
    parameter int CORDIC_STAGES  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  pixel_t               pixel,
    output logic                 colour_valid,
    input  logic                 colour_ready,
    output colour_t              colour,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int XW = SAMPLE_BITS + 11;
    localparam int IW = $clog2(COLOUR_ENTRIES);

    cfg_t cfg_reg;
    logic en;

    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    tag_t                          in_tag;

    tag_t                          cordic_tag;
    logic signed [XW-1:0]          cordic_x;
    logic signed [ZW-1:0]          cordic_z;
    logic signed [SAMPLE_BITS-1:0] cordic_re;
    logic signed [SAMPLE_BITS-1:0] cordic_im;

    tag_t                          win_tag;
    logic [IW-1:0]                 win_idx;
    logic [WIN_W-1:0]              win_bright;
    logic [LEVEL_W-1:0]            win_grey;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DISPLAY_MODE:     cfg_reg.display_mode     <= cfg_data[2:0];
                REG_PHASE_IN_DEGREES: cfg_reg.phase_in_degrees <= cfg_data[0];
                REG_WINDOW_LOW:       cfg_reg.window_low       <= $signed(cfg_data[17:0]);
                REG_WINDOW_GAIN:      cfg_reg.window_gain      <= cfg_data[23:0];
                REG_WINDOW_VALID:     cfg_reg.window_valid     <= cfg_data[0];
                REG_FULL_BRIGHT:      cfg_reg.full_bright      <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign en          = !colour_valid || colour_ready;
    assign pixel_ready = en;

    if (SAMPLE_BITS <= 16)
    begin : g_narrow
        assign re = pixel.real_part[SAMPLE_BITS-1:0];
        assign im = pixel.imag_part[SAMPLE_BITS-1:0];
    end
    else
    begin : g_wide
        assign re = {{(SAMPLE_BITS-16){1'b0}}, pixel.real_part};
        assign im = {{(SAMPLE_BITS-16){1'b0}}, pixel.imag_part};
    end

    assign in_tag.valid     = pixel_valid;
    assign in_tag.frame_end = pixel.frame_end;

    cpwcm_cordic #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (in_tag),
        .re      (re),
        .im      (im),
        .out_tag (cordic_tag),
        .x_out   (cordic_x),
        .z_out   (cordic_z),
        .re_out  (cordic_re),
        .im_out  (cordic_im)
    );

    cpwcm_window #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COLOUR_ENTRIES (COLOUR_ENTRIES)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_reg),
        .in_tag  (cordic_tag),
        .x       (cordic_x),
        .z       (cordic_z),
        .re      (cordic_re),
        .im      (cordic_im),
        .out_tag (win_tag),
        .idx     (win_idx),
        .bright  (win_bright),
        .grey    (win_grey)
    );

    cpwcm_colour #(
        .COLOUR_ENTRIES (COLOUR_ENTRIES),
        .CORDIC_STAGES  (CORDIC_STAGES)
    ) u_colour (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg_reg),
        .in_tag     (win_tag),
        .idx        (win_idx),
        .bright     (win_bright),
        .grey       (win_grey),
        .out_valid  (colour_valid),
        .out_colour (colour)
    );

endmodule

// ===== rtl/cpwcm_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cpwcm_checker
    import cpwcm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pixel_valid,
    input logic                 pixel_ready,
    input pixel_t               pixel,
    input logic                 colour_valid,
    input logic                 colour_ready,
    input colour_t              colour,
    input logic                 cfg_write,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    `CPWCM_ASSERT(a_ready_tracks_output, clk, rst_n, pixel_ready == (!colour_valid || colour_ready))
    `CPWCM_ASSERT(a_output_holds, clk, rst_n, colour_valid && !colour_ready |=> colour_valid && $stable(colour))
    `CPWCM_ASSERT_RST(a_empty_after_reset, clk, $rose(rst_n) |-> !colour_valid)

endmodule

bind complex_pixel_window_colour_map cpwcm_checker u_checker (.*);
